// ===== src/sql_text_minifier_unit_macros.svh =====
// ----------------------------------------------------------------------------
// SQL text minifier assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SQL_TEXT_MINIFIER_UNIT_MACROS_SVH
`define SQL_TEXT_MINIFIER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset
`define SQLM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sqlm assertion failed");

// Check that a condition implies a consequence in the next cycle
`define SQLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sqlm assertion failed");

`else

`define SQLM_ASSERT(label, clk, rst_n, prop)
`define SQLM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/sqlm_pkg.sv =====
// ----------------------------------------------------------------------------
// SQL text minifier package
// Shared types, character codes and queue sizing.
// ----------------------------------------------------------------------------
package sqlm_pkg;

  // Output bytes one request can produce
  localparam int MaxEmit = 3;
  localparam int EmitCntW = 2;

  // Request queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  // Character codes
  localparam logic [7:0] CharLbrack   = 8'h5B;
  localparam logic [7:0] CharRbrack   = 8'h5D;
  localparam logic [7:0] CharDash     = 8'h2D;
  localparam logic [7:0] CharSlash    = 8'h2F;
  localparam logic [7:0] CharStar     = 8'h2A;
  localparam logic [7:0] CharDot      = 8'h2E;
  localparam logic [7:0] CharNewline  = 8'h0A;
  localparam logic [7:0] CharBacktick = 8'h60;
  localparam logic [7:0] CharVtab     = 8'h0B;
  localparam logic [7:0] CharFormfeed = 8'h0C;
  localparam logic [7:0] CharReturn   = 8'h0D;
  localparam logic [7:0] CharTab      = 8'h09;
  localparam logic [7:0] CharSpace    = 8'h20;
  localparam logic [7:0] CharDquote   = 8'h22;
  localparam logic [7:0] CharSquote   = 8'h27;

  typedef enum logic [2:0] {
    MODE_GENERAL   = 3'd0,
    MODE_QUOTED    = 3'd1,
    MODE_LINE_CMT  = 3'd2,
    MODE_BLOCK_CMT = 3'd3,
    MODE_DOT       = 3'd4,
    MODE_DASH      = 3'd5,
    MODE_SLASH     = 3'd6
  } scan_mode_e;

  typedef struct packed {
    scan_mode_e  mode;
    logic [7:0]  close_char;
    logic        star_seen;
    logic        at_line_start;
    logic        space_pending;
    logic        output_after_space;
  } scan_state_t;

  localparam scan_state_t ScanReset = '{
    mode:               MODE_GENERAL,
    close_char:         8'h00,
    star_seen:          1'b0,
    at_line_start:      1'b1,
    space_pending:      1'b1,
    output_after_space: 1'b1
  };

  // Bytes produced by one request, handed from front to back
  typedef struct packed {
    logic [MaxEmit-1:0][7:0] bytes;
    logic [EmitCntW-1:0]     count;
    logic                    end_run;
  } emit_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;
  } out_rsp_t;

endpackage

// ===== src/sqlm_front.sv =====
// ----------------------------------------------------------------------------
// SQL text minifier front end
// Scans each input request, updates the scanner state and builds the list
// of output bytes it causes.
// ----------------------------------------------------------------------------
module sqlm_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sqlm_pkg::in_req_t in_req_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_add_final_newline_i,
  input  logic             q_full_i,
  output logic             push_o,
  output sqlm_pkg::emit_t  push_data_o
);

  typedef struct packed {
    sqlm_pkg::scan_state_t st;
    sqlm_pkg::emit_t       em;
  } step_t;

  function automatic logic is_break(logic [7:0] b);
    return (b == sqlm_pkg::CharNewline) || (b == sqlm_pkg::CharVtab) ||
           (b == sqlm_pkg::CharFormfeed) || (b == sqlm_pkg::CharReturn);
  endfunction

  function automatic step_t put_byte(step_t s, logic [7:0] b);
    if (s.em.count < sqlm_pkg::EmitCntW'(sqlm_pkg::MaxEmit)) begin
      s.em.bytes[s.em.count] = b;
      s.em.count = s.em.count + 1'b1;
    end
    s.st.output_after_space = 1'b0;
    return s;
  endfunction

  function automatic step_t put_sep(step_t s);
    if (s.st.space_pending && !s.st.output_after_space) begin
      s = put_byte(s, sqlm_pkg::CharSpace);
    end
    s.st.output_after_space = 1'b1;
    return s;
  endfunction

  function automatic step_t put_punct(step_t s, logic [7:0] b);
    s = put_byte(s, b);
    s.st.at_line_start = 1'b0;
    s.st.space_pending = 1'b1;
    s.st.output_after_space = 1'b1;
    return s;
  endfunction

  function automatic step_t general_byte(step_t s, logic [7:0] b);
    if (is_break(b)) begin
      s.st.at_line_start = 1'b1;
      s.st.space_pending = 1'b1;
    end else begin
      case (b) inside
        sqlm_pkg::CharTab, sqlm_pkg::CharSpace: begin
          s.st.space_pending = 1'b1;
        end
        sqlm_pkg::CharDquote, sqlm_pkg::CharSquote, sqlm_pkg::CharLbrack,
        sqlm_pkg::CharBacktick: begin
          s = put_sep(s);
          s = put_byte(s, b);
          s.st.close_char = (b == sqlm_pkg::CharLbrack) ? sqlm_pkg::CharRbrack : b;
          s.st.mode = sqlm_pkg::MODE_QUOTED;
        end
        sqlm_pkg::CharDot: begin
          if (s.st.at_line_start) begin
            s = put_byte(s, sqlm_pkg::CharNewline);
            s = put_byte(s, sqlm_pkg::CharDot);
            s.st.mode = sqlm_pkg::MODE_DOT;
          end else begin
            s = put_punct(s, b);
          end
        end
        "!", "%", "&", "(", ")", sqlm_pkg::CharStar, "+", ",", ";", "<", "=",
        ">", "|": begin
          s = put_punct(s, b);
        end
        sqlm_pkg::CharDash: begin
          s.st.mode = sqlm_pkg::MODE_DASH;
        end
        sqlm_pkg::CharSlash: begin
          s.st.mode = sqlm_pkg::MODE_SLASH;
        end
        default: begin
          s = put_sep(s);
          s = put_byte(s, b);
          s.st.at_line_start = 1'b0;
          s.st.space_pending = 1'b0;
        end
      endcase
    end
    return s;
  endfunction

  sqlm_pkg::scan_state_t state_q, state_d;
  logic                  add_final_newline_q;
  step_t                 s;
  logic [7:0]            b;
  logic                  accept;

  assign b = in_req_i.in_byte;
  assign in_ready_o = !q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept = in_valid_i && in_ready_o;

  // Scan one request
  always_comb begin
    s.st = state_q;
    s.em = '0;
    s.em.end_run = in_req_i.end_of_text;
    if (in_req_i.end_of_text) begin
      if (state_q.mode == sqlm_pkg::MODE_DASH) begin
        s = put_punct(s, sqlm_pkg::CharDash);
      end else if (state_q.mode == sqlm_pkg::MODE_SLASH) begin
        s = put_punct(s, sqlm_pkg::CharSlash);
      end
      if (add_final_newline_q) begin
        s = put_byte(s, sqlm_pkg::CharNewline);
      end
      s.st = sqlm_pkg::ScanReset;
    end else begin
      unique case (state_q.mode)
        sqlm_pkg::MODE_QUOTED: begin
          s = put_byte(s, b);
          if (b == state_q.close_char) begin
            s.st.space_pending = 1'b0;
            s.st.at_line_start = 1'b0;
            s.st.mode = sqlm_pkg::MODE_GENERAL;
          end
        end
        sqlm_pkg::MODE_LINE_CMT: begin
          if (is_break(b)) begin
            s.st.space_pending = 1'b1;
            s.st.at_line_start = 1'b1;
            s.st.mode = sqlm_pkg::MODE_GENERAL;
          end
        end
        sqlm_pkg::MODE_BLOCK_CMT: begin
          if (state_q.star_seen && b == sqlm_pkg::CharSlash) begin
            s.st.star_seen = 1'b0;
            s.st.space_pending = 1'b1;
            s.st.at_line_start = 1'b0;
            s.st.mode = sqlm_pkg::MODE_GENERAL;
          end else begin
            s.st.star_seen = (b == sqlm_pkg::CharStar);
          end
        end
        sqlm_pkg::MODE_DOT: begin
          if (is_break(b)) begin
            s = put_byte(s, sqlm_pkg::CharNewline);
            s.st.output_after_space = 1'b1;
            s.st.space_pending = 1'b1;
            s.st.at_line_start = 1'b1;
            s.st.mode = sqlm_pkg::MODE_GENERAL;
          end else begin
            s = put_byte(s, b);
          end
        end
        sqlm_pkg::MODE_DASH: begin
          if (b == sqlm_pkg::CharDash) begin
            s.st.mode = sqlm_pkg::MODE_LINE_CMT;
          end else begin
            s.st.mode = sqlm_pkg::MODE_GENERAL;
            s = put_punct(s, sqlm_pkg::CharDash);
            s = general_byte(s, b);
          end
        end
        sqlm_pkg::MODE_SLASH: begin
          if (b == sqlm_pkg::CharStar) begin
            s.st.star_seen = 1'b0;
            s.st.mode = sqlm_pkg::MODE_BLOCK_CMT;
          end else begin
            s.st.mode = sqlm_pkg::MODE_GENERAL;
            s = put_punct(s, sqlm_pkg::CharSlash);
            s = general_byte(s, b);
          end
        end
        default: begin
          s.st.mode = sqlm_pkg::MODE_GENERAL;
          s = general_byte(s, b);
        end
      endcase
    end
  end

  // Advance state on accept, push only requests that produce bytes
  assign state_d = accept ? s.st : state_q;
  assign push_o = accept && (s.em.count != '0);
  assign push_data_o = s.em;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sqlm_pkg::ScanReset;
      add_final_newline_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        add_final_newline_q <= cfg_add_final_newline_i;
      end
    end
  end

endmodule

// ===== src/sqlm_queue.sv =====
// ----------------------------------------------------------------------------
// SQL text minifier request queue
// Small FIFO of scanned requests between front end and output stage.
// ----------------------------------------------------------------------------
`include "sql_text_minifier_unit_macros.svh"

module sqlm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sqlm_pkg::emit_t push_data_i,
  input  logic            pop_i,
  output sqlm_pkg::emit_t head_o,
  output logic            full_o,
  output logic            empty_o
);

  sqlm_pkg::emit_t                 mem_q [sqlm_pkg::QDepth];
  logic [sqlm_pkg::QPtrW-1:0]      wr_q, rd_q;
  logic [sqlm_pkg::QCntW-1:0]      count_q, count_d;

  assign full_o  = (count_q == sqlm_pkg::QCntW'(sqlm_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_q];

  // Track fill level
  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `SQLM_ASSERT(a_no_push_full, clk_i, rst_ni, !(push_i && full_o))
  `SQLM_ASSERT(a_no_pop_empty, clk_i, rst_ni, !(pop_i && empty_o))
  `SQLM_ASSERT(a_count_range, clk_i, rst_ni, count_q <= sqlm_pkg::QCntW'(sqlm_pkg::QDepth))

endmodule

// ===== src/sqlm_back.sv =====
// ----------------------------------------------------------------------------
// SQL text minifier output stage
// Walks the queue head's bytes and hands them out one per cycle when ready.
// ----------------------------------------------------------------------------
`include "sql_text_minifier_unit_macros.svh"

module sqlm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sqlm_pkg::emit_t    head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sqlm_pkg::out_rsp_t out_rsp_o
);

  logic [sqlm_pkg::EmitCntW-1:0] idx_q, idx_d;
  logic                          last;
  logic                          fire;

  assign out_valid_o = !empty_i;
  assign last = (idx_q == head_i.count - 1'b1);
  assign fire = out_valid_o && out_ready_i;
  assign pop_o = fire && last;

  // Present the current byte of the head request
  assign out_rsp_o.out_byte    = head_i.bytes[idx_q];
  assign out_rsp_o.last_of_run = last;
  assign out_rsp_o.stream_done = last && head_i.end_run;

  // Advance within the request, restart on pop
  always_comb begin
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = '0;
    end else if (fire) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  `SQLM_ASSERT(a_idx_in_range, clk_i, rst_ni, !out_valid_o || (idx_q < head_i.count))
  `SQLM_ASSERT_NEXT(a_idx_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(idx_q))

endmodule

// ===== src/sql_text_minifier_unit.sv =====
// ----------------------------------------------------------------------------
// SQL text minifier
// Streaming minifier for SQL-like text, one byte per input request.
// ----------------------------------------------------------------------------
// One input request is accepted per cycle while the four-entry request queue
// has room. Each request yields zero to three output bytes; the output stage
// hands out one byte per cycle while out_ready_i is high, so a request that
// yields two or three bytes holds the output until all of them are taken. A
// byte becomes visible on the output once its request is in the queue and at
// its head. Comments and whitespace-only requests yield nothing and are not
// queued. add_final_newline may be written at any cycle while idle.
module sql_text_minifier_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sqlm_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sqlm_pkg::out_rsp_t out_rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_add_final_newline_i
);

  logic            push, pop, q_full, q_empty;
  sqlm_pkg::emit_t push_data, head;

  // Scan requests
  sqlm_front u_front (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid_i),
    .in_ready_o              (in_ready_o),
    .in_req_i                (in_req_i),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_o             (cfg_ready_o),
    .cfg_add_final_newline_i (cfg_add_final_newline_i),
    .q_full_i                (q_full),
    .push_o                  (push),
    .push_data_o             (push_data)
  );

  // Decouple scanning from output
  sqlm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Serialize output bytes
  sqlm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
